// ===== hw/rtl/tsa_pkg.sv =====
`default_nettype none

package tsa_pkg;

  // Item kinds carried on in_tuser.
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TRI  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IW = 8;
  localparam int unsigned CFG_DW = 11;
  localparam logic [CFG_IW-1:0] REG_VERTEX_COUNT = 8'd0;
  localparam logic [CFG_IW-1:0] REG_INDEX_MODE   = 8'd1;

  // Stream widths.
  localparam int unsigned IN_DW  = 192;
  localparam int unsigned IN_UW  = 2;
  localparam int unsigned OUT_DW = 192;
  localparam int unsigned OUT_UW = 2;

  // Corner index width: sequential corners reach 3*1023+2.
  localparam int unsigned KW = 12;
  // Vertex store word: x, y, z, u, v from the lowest bit up.
  localparam int unsigned VW = 160;
  // Accumulator word: six 48-bit sums, then the 16-bit use count.
  localparam int unsigned SW    = 48;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned ACC_W = 6 * SW + CNT_W;
  // Products, numerators and the divider.
  localparam int unsigned NUMW  = 65;
  localparam int unsigned QBITS = 33;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOAD,
    ST_VRD,
    ST_VLAT,
    ST_DIFF,
    ST_MUL,
    ST_MULW,
    ST_CHECK,
    ST_DIVINIT,
    ST_DIVSTEP,
    ST_DIVEND,
    ST_ACCRD,
    ST_ACCWR,
    ST_RDRD,
    ST_RDCLR,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       capture;
    logic       face_step;
    logic       vwrite;
    logic       vread;
    logic       vlatch;
    logic       diff;
    logic       mul;
    logic       mulw;
    logic       degen;
    logic       div_init;
    logic       div_step;
    logic       div_end;
    logic       acc_read;
    logic       acc_write;
    logic       acc_zero;
    logic       out_load;
    logic [2:0] sel;
    logic       half;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       a_ok;
    logic       tri_ok;
    logic       det_zero;
    logic       cnt_zero;
    logic       clear_last;
    logic       out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsa_ctrl.sv =====
`default_nettype none

module tsa_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  tsa_pkg::status_t st,
  output tsa_pkg::cmd_t    cmd
);

  tsa_pkg::state_t state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       half_r, half_nxt;
  logic [5:0] bit_r, bit_nxt;

  // State and sequencing counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsa_pkg::ST_CLEAR;
      idx_r   <= '0;
      half_r  <= 1'b0;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      half_r  <= half_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    half_nxt  = half_r;
    bit_nxt   = bit_r;
    case (state_r)
      tsa_pkg::ST_CLEAR: begin
        if (st.clear_last) state_nxt = tsa_pkg::ST_IDLE;
      end
      tsa_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = tsa_pkg::ST_DISPATCH;
      end
      tsa_pkg::ST_DISPATCH: begin
        idx_nxt  = '0;
        half_nxt = 1'b0;
        case (st.kind)
          tsa_pkg::KIND_LOAD: state_nxt = st.a_ok ? tsa_pkg::ST_LOAD : tsa_pkg::ST_IDLE;
          tsa_pkg::KIND_TRI:  state_nxt = st.tri_ok ? tsa_pkg::ST_VRD : tsa_pkg::ST_IDLE;
          tsa_pkg::KIND_READ: state_nxt = st.a_ok ? tsa_pkg::ST_RDRD : tsa_pkg::ST_IDLE;
          default:            state_nxt = tsa_pkg::ST_IDLE;
        endcase
      end
      tsa_pkg::ST_LOAD: state_nxt = tsa_pkg::ST_IDLE;
      tsa_pkg::ST_VRD:  state_nxt = tsa_pkg::ST_VLAT;
      tsa_pkg::ST_VLAT: begin
        if (idx_r == 3'd2) begin
          idx_nxt   = '0;
          state_nxt = tsa_pkg::ST_DIFF;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = tsa_pkg::ST_VRD;
        end
      end
      tsa_pkg::ST_DIFF: state_nxt = tsa_pkg::ST_MUL;
      tsa_pkg::ST_MUL:  state_nxt = tsa_pkg::ST_MULW;
      tsa_pkg::ST_MULW: begin
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = tsa_pkg::ST_MUL;
        end else begin
          half_nxt = 1'b0;
          if (idx_r == 3'd6) begin
            idx_nxt   = '0;
            state_nxt = tsa_pkg::ST_CHECK;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = tsa_pkg::ST_MUL;
          end
        end
      end
      tsa_pkg::ST_CHECK: begin
        state_nxt = st.det_zero ? tsa_pkg::ST_IDLE : tsa_pkg::ST_DIVINIT;
      end
      tsa_pkg::ST_DIVINIT: begin
        bit_nxt   = '0;
        state_nxt = tsa_pkg::ST_DIVSTEP;
      end
      tsa_pkg::ST_DIVSTEP: begin
        if (bit_r == 6'(tsa_pkg::QBITS - 1)) state_nxt = tsa_pkg::ST_DIVEND;
        else bit_nxt = bit_r + 6'd1;
      end
      tsa_pkg::ST_DIVEND: begin
        if (idx_r == 3'd5) begin
          idx_nxt   = '0;
          state_nxt = (st.kind == tsa_pkg::KIND_READ) ? tsa_pkg::ST_OUT : tsa_pkg::ST_ACCRD;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = tsa_pkg::ST_DIVINIT;
        end
      end
      tsa_pkg::ST_ACCRD: state_nxt = tsa_pkg::ST_ACCWR;
      tsa_pkg::ST_ACCWR: begin
        if (idx_r == 3'd2) begin
          idx_nxt   = '0;
          state_nxt = tsa_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = tsa_pkg::ST_ACCRD;
        end
      end
      tsa_pkg::ST_RDRD: state_nxt = tsa_pkg::ST_RDCLR;
      tsa_pkg::ST_RDCLR: begin
        idx_nxt   = '0;
        state_nxt = st.cnt_zero ? tsa_pkg::ST_OUT : tsa_pkg::ST_DIVINIT;
      end
      tsa_pkg::ST_OUT: begin
        if (st.out_free) state_nxt = tsa_pkg::ST_IDLE;
      end
      default: state_nxt = tsa_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd       = '0;
    cmd.sel   = idx_r;
    cmd.half  = half_r;
    in_tready = 1'b0;
    case (state_r)
      tsa_pkg::ST_CLEAR: cmd.clear = 1'b1;
      tsa_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      tsa_pkg::ST_DISPATCH: cmd.face_step = (st.kind == tsa_pkg::KIND_TRI);
      tsa_pkg::ST_LOAD:     cmd.vwrite    = 1'b1;
      tsa_pkg::ST_VRD:      cmd.vread     = 1'b1;
      tsa_pkg::ST_VLAT:     cmd.vlatch    = 1'b1;
      tsa_pkg::ST_DIFF:     cmd.diff      = 1'b1;
      tsa_pkg::ST_MUL:      cmd.mul       = 1'b1;
      tsa_pkg::ST_MULW:     cmd.mulw      = 1'b1;
      tsa_pkg::ST_CHECK:    cmd.degen     = st.det_zero;
      tsa_pkg::ST_DIVINIT:  cmd.div_init  = 1'b1;
      tsa_pkg::ST_DIVSTEP:  cmd.div_step  = 1'b1;
      tsa_pkg::ST_DIVEND:   cmd.div_end   = 1'b1;
      tsa_pkg::ST_ACCRD:    cmd.acc_read  = 1'b1;
      tsa_pkg::ST_ACCWR:    cmd.acc_write = 1'b1;
      tsa_pkg::ST_RDRD:     cmd.acc_read  = 1'b1;
      tsa_pkg::ST_RDCLR:    cmd.acc_zero  = 1'b1;
      tsa_pkg::ST_OUT:      cmd.out_load  = st.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsa_dp.sv =====
`default_nettype none

module tsa_dp #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tsa_pkg::cmd_t                cmd,
  output tsa_pkg::status_t             st,
  input  wire [tsa_pkg::IN_DW-1:0]     in_tdata,
  input  wire [tsa_pkg::IN_UW-1:0]     in_tuser,
  input  wire                          cfg_valid,
  input  wire [tsa_pkg::CFG_IW-1:0]    cfg_index,
  input  wire [tsa_pkg::CFG_DW-1:0]    cfg_data,
  input  wire                          out_tready,
  output logic                         out_tvalid,
  output logic [tsa_pkg::OUT_DW-1:0]   out_tdata,
  output logic [tsa_pkg::OUT_UW-1:0]   out_tuser
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [16:0] MAX_L = 17'(MAX_VERTICES);
  localparam int KW = tsa_pkg::KW;
  localparam int NW = tsa_pkg::NUMW;

  function automatic logic [31:0] sat32(input logic [32:0] s);
    logic [31:0] r;
    if (s[32] != s[31]) r = s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic [47:0] sat48(input logic [48:0] s);
    logic [47:0] r;
    if (s[48] != s[47]) r = s[48] ? 48'h8000_0000_0000 : 48'h7fff_ffff_ffff;
    else r = s[47:0];
    return r;
  endfunction

  function automatic logic [31:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    return sat32({a[31], a} - {b[31], b});
  endfunction

  // Configuration registers.
  logic [10:0] vc_r;
  logic        im_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 11'd1024;
      im_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsa_pkg::REG_VERTEX_COUNT: vc_r <= cfg_data;
        tsa_pkg::REG_INDEX_MODE:   im_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic logic kvalid(input logic [KW-1:0] k, input logic [10:0] vc);
    return ({1'b0, k} < {2'b0, vc}) && ({5'b0, k} < MAX_L);
  endfunction

  // Item capture: corners, kind and payload.
  logic [9:0]    face_r;
  logic          degen_r;
  logic [1:0]    kind_r;
  logic [KW-1:0] k_r [3];
  logic          a_ok_r, tri_ok_r;
  logic [tsa_pkg::VW-1:0] pl_r;
  logic [KW-1:0] base, k0_c, k1_c, k2_c;
  logic          seq_tri;

  assign base    = {1'b0, face_r, 1'b0} + {2'b0, face_r};
  assign seq_tri = (in_tuser == tsa_pkg::KIND_TRI) && !im_r;
  assign k0_c    = seq_tri ? base : {2'b0, in_tdata[9:0]};
  assign k1_c    = seq_tri ? base + 12'd1 : {2'b0, in_tdata[19:10]};
  assign k2_c    = seq_tri ? base + 12'd2 : {2'b0, in_tdata[29:20]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r   <= in_tuser;
      k_r[0]   <= k0_c;
      k_r[1]   <= k1_c;
      k_r[2]   <= k2_c;
      a_ok_r   <= kvalid(k0_c, vc_r);
      tri_ok_r <= kvalid(k0_c, vc_r) && kvalid(k1_c, vc_r) && kvalid(k2_c, vc_r);
      pl_r     <= in_tdata[189:30];
    end
  end

  // Face counter and degenerate flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_r  <= '0;
      degen_r <= 1'b0;
    end else begin
      if (cmd.face_step && !im_r) face_r <= face_r + 10'd1;
      if (cmd.degen) degen_r <= 1'b1;
    end
  end

  // Corner chosen by the sequencer.
  logic [KW-1:0] ksel;
  always_comb begin
    case (cmd.sel)
      3'd1:    ksel = k_r[1];
      3'd2:    ksel = k_r[2];
      default: ksel = k_r[0];
    endcase
  end

  // Vertex store: position and texture coordinate per vertex.
  logic [tsa_pkg::VW-1:0] vmem [MAX_VERTICES];
  logic [tsa_pkg::VW-1:0] vq_r;
  always_ff @(posedge clk) begin
    if (cmd.vwrite) vmem[AW'(k_r[0])] <= pl_r;
    if (cmd.vread) vq_r <= vmem[AW'(ksel)];
  end

  // The three corners, then edges and texture deltas.
  logic [tsa_pkg::VW-1:0] vtx_r [3];
  logic [31:0] e1_r [3];
  logic [31:0] e2_r [3];
  logic [31:0] d1u_r, d1v_r, d2u_r, d2v_r;
  always_ff @(posedge clk) begin
    if (cmd.vlatch) begin
      case (cmd.sel)
        3'd1:    vtx_r[1] <= vq_r;
        3'd2:    vtx_r[2] <= vq_r;
        default: vtx_r[0] <= vq_r;
      endcase
    end
    if (cmd.diff) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= sdiff(vtx_r[1][32*i +: 32], vtx_r[0][32*i +: 32]);
        e2_r[i] <= sdiff(vtx_r[2][32*i +: 32], vtx_r[0][32*i +: 32]);
      end
      d1u_r <= sdiff(vtx_r[1][96 +: 32], vtx_r[0][96 +: 32]);
      d1v_r <= sdiff(vtx_r[1][128 +: 32], vtx_r[0][128 +: 32]);
      d2u_r <= sdiff(vtx_r[2][96 +: 32], vtx_r[0][96 +: 32]);
      d2v_r <= sdiff(vtx_r[2][128 +: 32], vtx_r[0][128 +: 32]);
    end
  end

  // Shared multiplier. Entry 0 is the determinant, 1..3 the tangent
  // numerators and 4..6 the bitangent numerators, each first minus second product.
  logic [31:0] opa, opb;
  always_comb begin
    case (cmd.sel)
      3'd0: begin
        opa = cmd.half ? d2u_r : d1u_r;
        opb = cmd.half ? d1v_r : d2v_r;
      end
      3'd1, 3'd2, 3'd3: begin
        opa = cmd.half ? d1v_r : d2v_r;
        opb = cmd.half ? e2_r[2'(cmd.sel - 3'd1)] : e1_r[2'(cmd.sel - 3'd1)];
      end
      3'd4, 3'd5, 3'd6: begin
        opa = cmd.half ? d2u_r : d1u_r;
        opb = cmd.half ? e1_r[2'(cmd.sel - 3'd4)] : e2_r[2'(cmd.sel - 3'd4)];
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  logic [63:0]   prod_r, pfirst_r;
  logic [NW-1:0] num_r [7];
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= $signed(opa) * $signed(opb);
    if (cmd.mulw) begin
      if (!cmd.half) pfirst_r <= prod_r;
      else num_r[cmd.sel] <= {pfirst_r[63], pfirst_r} - {prod_r[63], prod_r};
    end
  end

  // Accumulator store with a clearing sweep after reset.
  logic [tsa_pkg::ACC_W-1:0] amem [MAX_VERTICES];
  logic [tsa_pkg::ACC_W-1:0] aq_r, upd, awdata;
  logic [AW-1:0]             clr_r, awaddr;
  logic                      awe;
  logic [31:0]               res_r [6];
  logic [tsa_pkg::CNT_W-1:0] cnt_q;

  assign cnt_q = aq_r[6*tsa_pkg::SW +: tsa_pkg::CNT_W];

  always_comb begin
    for (int f = 0; f < 6; f++) begin
      upd[tsa_pkg::SW*f +: tsa_pkg::SW] = sat48(
        {aq_r[tsa_pkg::SW*f + tsa_pkg::SW - 1], aq_r[tsa_pkg::SW*f +: tsa_pkg::SW]} +
        {{17{res_r[f][31]}}, res_r[f]});
    end
    upd[6*tsa_pkg::SW +: tsa_pkg::CNT_W] = (cnt_q == 16'hffff) ? cnt_q : cnt_q + 16'd1;
  end

  assign awe    = cmd.clear | cmd.acc_write | cmd.acc_zero;
  assign awaddr = cmd.clear ? clr_r : (cmd.acc_zero ? AW'(k_r[0]) : AW'(ksel));
  assign awdata = cmd.acc_write ? upd : '0;

  always_ff @(posedge clk) begin
    if (awe) amem[awaddr] <= awdata;
    if (cmd.acc_read) aq_r <= amem[AW'(ksel)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear) clr_r <= clr_r + AW'(1);
  end

  // Bit-serial divider: floor(|n| * 2^s / |d|), 33 quotient bits, overflow flagged.
  logic [NW-1:0] dnum, dden, nmag, dmag, dmag_r, rem_r;
  logic [80:0]   nfull;
  logic [32:0]   nlow_r, quo_r;
  logic          ovf_r, neg_r, ge;
  logic [NW:0]   trial;

  always_comb begin
    if (kind_r == tsa_pkg::KIND_READ) begin
      dnum = {{17{aq_r[tsa_pkg::SW*cmd.sel + tsa_pkg::SW - 1]}},
              aq_r[tsa_pkg::SW*cmd.sel +: tsa_pkg::SW]};
      dden = {49'b0, cnt_q};
    end else begin
      dnum = num_r[cmd.sel + 3'd1];
      dden = num_r[0];
    end
    nmag  = dnum[NW-1] ? (~dnum + 65'd1) : dnum;
    dmag  = dden[NW-1] ? (~dden + 65'd1) : dden;
    nfull = (kind_r == tsa_pkg::KIND_READ) ? {16'b0, nmag} : {nmag, 16'b0};
    trial = {rem_r, nlow_r[32]};
    ge    = trial >= {1'b0, dmag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= {17'b0, nfull[80:33]};
      ovf_r  <= {17'b0, nfull[80:33]} >= dmag;
      nlow_r <= nfull[32:0];
      quo_r  <= '0;
      neg_r  <= dnum[NW-1] ^ dden[NW-1];
      dmag_r <= dmag;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? NW'(trial - {1'b0, dmag_r}) : NW'(trial);
      quo_r  <= {quo_r[31:0], ge};
      nlow_r <= {nlow_r[31:0], 1'b0};
    end
    if (cmd.div_end) begin
      if (ovf_r || quo_r[32] || quo_r[31])
        res_r[cmd.sel] <= neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
      else
        res_r[cmd.sel] <= neg_r ? (~quo_r[31:0] + 32'd1) : quo_r[31:0];
    end
  end

  // Output register.
  logic        ovalid_r;
  logic [191:0] odata_r;
  logic [1:0]  ouser_r;
  logic        unused;
  assign unused = (cnt_q == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      odata_r <= unused ? '0 :
                 {res_r[5], res_r[4], res_r[3], res_r[2], res_r[1], res_r[0]};
      ouser_r <= {degen_r, unused};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

  // Status to the controller.
  always_comb begin
    st.kind       = kind_r;
    st.a_ok       = a_ok_r;
    st.tri_ok     = tri_ok_r;
    st.det_zero   = (num_r[0] == '0);
    st.cnt_zero   = unused;
    st.clear_last = (clr_r == AW'(MAX_VERTICES - 1));
    st.out_free   = !ovalid_r || out_tready;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tangent_space_accumulator.sv =====
`default_nettype none

// Tangent and bitangent accumulator for indexed or sequential triangle meshes in
// s15.16 fixed point. After reset the accumulator store is swept to zero, one
// vertex per cycle, and no input beat is taken until the sweep ends (configuration
// writes are always taken). A triangle beat and a read beat of a used vertex both
// pass through one bit-serial divider that forms six quotients of 33 steps each;
// for a triangle the rest is three vertex reads, fourteen products on one 32x32
// multiplier, and three read-modify-writes of the accumulator store. Shorter paths
// skip the divider: a triangle with a corner out of range or a flat UV mapping, a
// read of an unused vertex, and any other dropped beat. A read also waits while the
// previous result still sits unaccepted in the output register. A finished result
// waits in that output register while the next beat is accepted.
module tangent_space_accumulator #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_tvalid,
  output logic                       in_tready,
  // index_a[9:0], index_b[19:10], index_c[29:20], pos_x[61:30], pos_y[93:62],
  // pos_z[125:94], tex_u[157:126], tex_v[189:158], zero fill
  input  wire [tsa_pkg::IN_DW-1:0]   in_tdata,
  // kind[1:0]
  input  wire [tsa_pkg::IN_UW-1:0]   in_tuser,
  output logic                       out_tvalid,
  input  wire                        out_tready,
  // tangent_x[31:0], tangent_y[63:32], tangent_z[95:64], bitangent_x[127:96],
  // bitangent_y[159:128], bitangent_z[191:160]
  output logic [tsa_pkg::OUT_DW-1:0] out_tdata,
  // unused_vertex[0], degenerate_seen[1]
  output logic [tsa_pkg::OUT_UW-1:0] out_tuser,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [tsa_pkg::CFG_IW-1:0]  cfg_index,
  input  wire [tsa_pkg::CFG_DW-1:0]  cfg_data
);

  tsa_pkg::cmd_t    cmd;
  tsa_pkg::status_t st;

  assign cfg_ready = 1'b1;

  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  tsa_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tangent_space_accumulator_tb.sv =====
`default_nettype none

module tangent_space_accumulator_tb;

  localparam logic [tsa_pkg::CFG_IW-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam int NVERT = 1024;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -64'sh8000_0000_0000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [1:0]         kind;
    logic [9:0]         ia;
    logic [9:0]         ib;
    logic [9:0]         ic;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] tu;
    logic signed [31:0] tv;
  } mesh_beat_t;

  typedef struct {
    logic [5:0][31:0] vec;
    logic             unused;
    logic             degen;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tsa_pkg::IN_DW-1:0] in_tdata = '0;
  logic [tsa_pkg::IN_UW-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tsa_pkg::OUT_DW-1:0] out_tdata;
  logic [tsa_pkg::OUT_UW-1:0] out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [tsa_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [tsa_pkg::CFG_DW-1:0] cfg_data = '0;

  tangent_space_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow of the block: vertex stores, accumulators and registers.
  logic signed [31:0] pos_mem[0:NVERT-1][0:2];
  logic signed [31:0] uv_mem[0:NVERT-1][0:1];
  longint tan_sum[0:NVERT-1][0:2];
  longint bit_sum[0:NVERT-1][0:2];
  int use_cnt[0:NVERT-1];
  int face_num = 0;
  bit degen_seen = 0;
  int live_count = 1024;
  bit indexed = 1;

  mesh_beat_t pending_beats[$];
  frame_t frames_due[$];
  mesh_beat_t cur_beat;
  bit in_fire = 0;
  bit cfg_fire = 0;
  int errors = 0;
  bit hold_request = 0;

  // Generator view: which vertices are safe to reference.
  bit gen_written[0:NVERT-1];
  int gen_pool[$];
  int gen_count = 1024;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [65:0] wide(longint v);
    logic signed [65:0] w;
    w = 66'(v);
    return w;
  endfunction

  // num * 2^16 / den, truncated toward zero and saturated to 32 bits.
  function automatic longint quot_q16(logic signed [65:0] num, logic signed [65:0] den);
    logic [65:0] n;
    logic [65:0] d;
    logic [81:0] q;
    bit neg;
    neg = (num < 0) != (den < 0);
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = {n, 16'b0} / {16'b0, d};
    if (neg) return q >= 82'h8000_0000 ? S32_MIN : -longint'(q);
    return q > 82'h7FFF_FFFF ? S32_MAX : longint'(q);
  endfunction

  function automatic bit vertex_ok(int i);
    return i < live_count && i < NVERT;
  endfunction

  task automatic accumulate_triangle(int ka, int kb, int kc);
    int k[3];
    longint e1[3];
    longint e2[3];
    longint d1u, d1v, d2u, d2v;
    logic signed [65:0] det;
    longint tq[3];
    longint bq[3];
    k = '{ka, kb, kc};
    if (!vertex_ok(ka) || !vertex_ok(kb) || !vertex_ok(kc)) return;
    for (int i = 0; i < 3; i++) begin
      e1[i] = clamp(longint'(pos_mem[kb][i]) - longint'(pos_mem[ka][i]), S32_MIN, S32_MAX);
      e2[i] = clamp(longint'(pos_mem[kc][i]) - longint'(pos_mem[ka][i]), S32_MIN, S32_MAX);
    end
    d1u = clamp(longint'(uv_mem[kb][0]) - longint'(uv_mem[ka][0]), S32_MIN, S32_MAX);
    d1v = clamp(longint'(uv_mem[kb][1]) - longint'(uv_mem[ka][1]), S32_MIN, S32_MAX);
    d2u = clamp(longint'(uv_mem[kc][0]) - longint'(uv_mem[ka][0]), S32_MIN, S32_MAX);
    d2v = clamp(longint'(uv_mem[kc][1]) - longint'(uv_mem[ka][1]), S32_MIN, S32_MAX);
    det = wide(d1u) * wide(d2v) - wide(d2u) * wide(d1v);
    // A flat UV mapping gives no tangent frame: skip it and remember it.
    if (det == 0) begin
      degen_seen = 1;
      return;
    end
    for (int i = 0; i < 3; i++) begin
      tq[i] = quot_q16(wide(d2v) * wide(e1[i]) - wide(d1v) * wide(e2[i]), det);
      bq[i] = quot_q16(wide(d1u) * wide(e2[i]) - wide(d2u) * wide(e1[i]), det);
    end
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 3; i++) begin
        tan_sum[k[c]][i] = clamp(tan_sum[k[c]][i] + tq[i], S48_MIN, S48_MAX);
        bit_sum[k[c]][i] = clamp(bit_sum[k[c]][i] + bq[i], S48_MIN, S48_MAX);
      end
      if (use_cnt[k[c]] != 65535) use_cnt[k[c]]++;
    end
  endtask

  task automatic predict_beat(mesh_beat_t b);
    frame_t f;
    int v;
    longint s;
    v = int'(b.ia);
    case (b.kind)
      tsa_pkg::KIND_LOAD: begin
        if (vertex_ok(v)) begin
          pos_mem[v] = '{b.px, b.py, b.pz};
          uv_mem[v] = '{b.tu, b.tv};
        end
      end
      tsa_pkg::KIND_TRI: begin
        if (indexed) begin
          accumulate_triangle(int'(b.ia), int'(b.ib), int'(b.ic));
        end else begin
          accumulate_triangle(face_num * 3, face_num * 3 + 1, face_num * 3 + 2);
          face_num = (face_num + 1) % 1024;
        end
      end
      tsa_pkg::KIND_READ: begin
        if (vertex_ok(v)) begin
          f.vec = '0;
          for (int i = 0; i < 6; i++) begin
            s = i < 3 ? tan_sum[v][i] : bit_sum[v][i - 3];
            if (use_cnt[v] != 0)
              f.vec[i] = 32'(clamp(s / longint'(use_cnt[v]), S32_MIN, S32_MAX));
          end
          f.unused = use_cnt[v] == 0;
          f.degen = degen_seen;
          frames_due.push_back(f);
          tan_sum[v] = '{0, 0, 0};
          bit_sum[v] = '{0, 0, 0};
          use_cnt[v] = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Sample both channels at the rising edge; compare results with the oldest frame due.
  always @(posedge clk) begin
    frame_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (frames_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: data %h user %b", out_tdata, out_tuser);
        end else begin
          want = frames_due.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (out_tdata[32*i +: 32] !== want.vec[i]) begin
              errors++;
              if (errors <= 10)
                $display("vector word %0d mismatch: expected %h got %h", i, want.vec[i],
                         out_tdata[32*i +: 32]);
            end
          end
          if (out_tuser !== {want.degen, want.unused}) begin
            errors++;
            if (errors <= 10)
              $display("flags mismatch: expected %b got %b", {want.degen, want.unused}, out_tuser);
          end
        end
      end
      in_fire = in_tvalid && in_tready;
      if (in_fire) predict_beat(cur_beat);
      cfg_fire = cfg_valid && cfg_ready;
      if (cfg_fire) begin
        if (cfg_index == tsa_pkg::REG_VERTEX_COUNT) live_count = int'(cfg_data);
        else if (cfg_index == tsa_pkg::REG_INDEX_MODE) indexed = cfg_data[0];
      end
    end
  end

  function automatic int draw_gap(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) quiet = $urandom_range(10, 40);
    if (r < 45) return 0;
    if (r < 93) return $urandom_range(1, 5);
    return $urandom_range(20, 300);
  endfunction

  // Input driver: next beat from the queue, with random gaps.
  int in_gap = 0;
  int in_quiet = 0;
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_fire)) begin
      in_fire = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_tdata <= {2'b0, cur_beat.tv, cur_beat.tu, cur_beat.pz, cur_beat.py, cur_beat.px,
                     cur_beat.ic, cur_beat.ib, cur_beat.ia};
        in_tuser <= cur_beat.kind;
        in_tvalid <= 1'b1;
        in_gap = draw_gap(in_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  int hold_left = 0;
  int stall_left = 0;
  int out_quiet = 0;
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      stall_left = draw_gap(out_quiet);
      out_tready <= stall_left == 0;
    end
  end

  function automatic logic [31:0] draw_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return int'($urandom_range(0, 524288)) - 262144;
      5, 6: return $urandom;
      7: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return int'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  function automatic mesh_beat_t make_beat(logic [1:0] kind, int a, int b, int c,
                                           logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                           logic [31:0] tu, logic [31:0] tv);
    mesh_beat_t m;
    m.kind = kind;
    m.ia = 10'(a);
    m.ib = 10'(b);
    m.ic = 10'(c);
    m.px = px;
    m.py = py;
    m.pz = pz;
    m.tu = tu;
    m.tv = tv;
    return m;
  endfunction

  task automatic queue_beat(mesh_beat_t m);
    if (m.kind == tsa_pkg::KIND_LOAD && m.ia < gen_count && !gen_written[m.ia]) begin
      gen_written[m.ia] = 1;
      gen_pool.push_back(int'(m.ia));
    end
    pending_beats.push_back(m);
  endtask

  function automatic int pick_corner();
    int idx;
    if ($urandom_range(0, 99) < 85) return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
    idx = $urandom_range(0, NVERT - 1);
    if (idx < gen_count && !gen_written[idx]) idx = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
    return idx;
  endfunction

  task automatic queue_random(int n, int p_load, int p_tri, int p_read, int near);
    int r, a, b, c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (gen_pool.size() == 0 && r >= p_load && r < p_load + p_tri) r = 0;
      if (r < p_load) begin
        a = $urandom_range(0, 99) < 70 ? $urandom_range(0, near) : $urandom_range(0, NVERT - 1);
        queue_beat(make_beat(tsa_pkg::KIND_LOAD, a, $urandom_range(0, 1023),
                             $urandom_range(0, 1023),
                             draw_value(), draw_value(), draw_value(), draw_value(), draw_value()));
      end else if (r < p_load + p_tri) begin
        a = pick_corner();
        b = $urandom_range(0, 99) < 5 ? a : pick_corner();
        c = pick_corner();
        queue_beat(make_beat(tsa_pkg::KIND_TRI, a, b, c, $urandom, $urandom, $urandom,
                             $urandom, $urandom));
      end else if (r < p_load + p_tri + p_read) begin
        a = $urandom_range(0, 99) < 70 ? $urandom_range(0, near) : $urandom_range(0, NVERT - 1);
        queue_beat(make_beat(tsa_pkg::KIND_READ, a, $urandom_range(0, 1023),
                             $urandom_range(0, 1023),
                             $urandom, $urandom, $urandom, $urandom, $urandom));
      end else begin
        queue_beat(make_beat(KIND_UNKNOWN, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom, $urandom, $urandom, $urandom,
                             $urandom));
      end
    end
  endtask

  // Wait until every beat is taken and every result is back, then let the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_tvalid || frames_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tsa_pkg::CFG_IW-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= tsa_pkg::CFG_DW'(value);
    do @(negedge clk);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  localparam logic [31:0] ONE = 32'h0001_0000;

  initial begin
    for (int i = 0; i < NVERT; i++) begin
      pos_mem[i] = '{0, 0, 0};
      uv_mem[i] = '{0, 0};
      tan_sum[i] = '{0, 0, 0};
      bit_sum[i] = '{0, 0, 0};
      use_cnt[i] = 0;
      gen_written[i] = 0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: a unit triangle, saturating edges and quotients, a flat UV mapping.
    queue_beat(make_beat(tsa_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_LOAD, 1, 0, 0, ONE, 0, 0, ONE, 0));
    queue_beat(make_beat(tsa_pkg::KIND_LOAD, 2, 0, 0, 0, ONE, 0, 0, ONE));
    queue_beat(make_beat(tsa_pkg::KIND_TRI, 0, 1, 2, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_LOAD, 1023, 1023, 1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 0, 1));
    queue_beat(make_beat(tsa_pkg::KIND_LOAD, 4, 0, 0, 32'h8000_0000, 32'h8000_0000,
                         32'h8000_0000, 1, 0));
    queue_beat(make_beat(tsa_pkg::KIND_LOAD, 5, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    queue_beat(make_beat(tsa_pkg::KIND_TRI, 0, 4, 1023, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_TRI, 1023, 5, 4, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_TRI, 0, 1, 2, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 2, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_TRI, 0, 0, 1, 0, 0, 0, 0, 0));
    queue_beat(make_beat(KIND_UNKNOWN, 1023, 1023, 1023, '1, '1, '1, '1, '1));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 1023, 1023, 1023, '1, '1, '1, '1, '1));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 4, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 5, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 1, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_beat(make_beat(tsa_pkg::KIND_READ, 777, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Full mesh, indexed corners.
    write_reg(tsa_pkg::REG_INDEX_MODE, 1);
    queue_random(300, 30, 40, 27, 31);
    wait_idle();

    // Few vertices: many loads, reads and corners fall out of range.
    gen_count = 37;
    write_reg(tsa_pkg::REG_VERTEX_COUNT, 37);
    queue_random(150, 30, 40, 27, 47);
    wait_idle();

    // No vertices at all: everything is dropped.
    gen_count = 0;
    write_reg(tsa_pkg::REG_VERTEX_COUNT, 0);
    queue_random(25, 30, 40, 27, 31);
    wait_idle();

    // Sequential faces over a fully loaded range.
    gen_count = 300;
    write_reg(tsa_pkg::REG_VERTEX_COUNT, 300);
    write_reg(tsa_pkg::REG_INDEX_MODE, 0);
    for (int i = 0; i < 300; i++)
      queue_beat(make_beat(tsa_pkg::KIND_LOAD, i, $urandom_range(0, 1023),
                           $urandom_range(0, 1023),
                           draw_value(), draw_value(), draw_value(), draw_value(), draw_value()));
    queue_random(200, 15, 45, 37, 320);
    wait_idle();

    // Back to the full mesh, with the receiver holding off to fill the block.
    gen_count = 1024;
    write_reg(tsa_pkg::REG_VERTEX_COUNT, 1024);
    write_reg(tsa_pkg::REG_INDEX_MODE, 1);
    write_reg(REG_UNMAPPED, 5);
    hold_request = 1;
    queue_random(100, 20, 20, 57, 31);
    wait_idle();

    if (errors == 0 && frames_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/tsa_pkg.sv
hw/rtl/tsa_ctrl.sv
hw/rtl/tsa_dp.sv
hw/rtl/tangent_space_accumulator.sv
tb/sv/tangent_space_accumulator_tb.sv
